[hw/rtl/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and constants for the particle floor collision block
// Register map, divider stage helper and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  localparam int DIV_BITS      = 48;   // dividend magnitude width (|v| << 16)
  localparam int DIV_PER_STAGE = 4;    // quotient bits resolved per stage
  localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;
  localparam int DEN_W         = 34;   // radius width
  localparam int REM_W         = DEN_W;

  localparam logic [16:0]      ONE_Q16    = 17'd65536;
  localparam logic [DEN_W-1:0] MIN_RADIUS = DEN_W'(66);

  localparam int FLAG_ENABLE = 0;
  localparam int FLAG_ROLL   = 1;
  localparam int FLAG_SCALE  = 2;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_PLANE    = 3'd1,
    REG_OFFSET   = 3'd2,
    REG_BOUNCE   = 3'd3,
    REG_FRICTION = 3'd4,
    REG_REST     = 3'd5,
    REG_RADIUS   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [DIV_BITS-1:0] dq;   // dividend bits out at the top, quotient bits in below
  } div_state_t;

  typedef struct packed {
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               contact;
    logic               spin;
    logic               neg_x;
    logic               neg_z;
  } carry_t;

  // Restoring division, DIV_PER_STAGE bits.
  function automatic div_state_t div_step(input div_state_t st, input logic [DEN_W-1:0] den);
    logic [REM_W:0] trial;
    div_state_t     r;
    r = st;
    for (int i = 0; i < DIV_PER_STAGE; i++) begin
      trial = {r.rem, r.dq[DIV_BITS-1]};
      if (trial >= {1'b0, den}) begin
        r.rem = REM_W'(trial - {1'b0, den});
        r.dq  = {r.dq[DIV_BITS-2:0], 1'b1};
      end else begin
        r.rem = trial[REM_W-1:0];
        r.dq  = {r.dq[DIV_BITS-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pfc_if.sv]
// ----------------------------------------------------------------------------
// pfc_if: request and result channels of the particle floor collision block
// Valid/ready handshake with the payload fields as separate signals.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfc_particle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] scale_y;
  logic [16:0]        delta_time;

  modport source (output valid, pos_y, vel_x, vel_y, vel_z, scale_y, delta_time,
                  input ready);
  modport sink   (input valid, pos_y, vel_x, vel_y, vel_z, scale_y, delta_time,
                  output ready);
endinterface

interface pfc_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;
  logic signed [31:0] spin_x;
  logic signed [31:0] spin_z;
  logic               spin_write;
  logic               contact;

  modport source (output valid, new_pos_y, new_vel_x, new_vel_y, new_vel_z, spin_x, spin_z,
                  spin_write, contact, input ready);
  modport sink   (input valid, new_pos_y, new_vel_x, new_vel_y, new_vel_z, spin_x, spin_z,
                  spin_write, contact, output ready);
endinterface

`default_nettype wire

[hw/rtl/particle_floor_collision.sv]
// ----------------------------------------------------------------------------
// particle_floor_collision: floor contact response for a stream of particles
// Lifts particles onto a horizontal floor, bounces or lands them, applies
// friction and optionally rebuilds the rolling spin.
// ----------------------------------------------------------------------------
// Usage:
//   particle : request channel, one particle per request (valid/ready).
//   result   : one result per request, in request order (valid/ready).
//   APB port : seven configuration registers at byte addresses 4*i; write
//              them only while no request is in flight. pready is tied high.
// From acceptance to result valid a request passes four arithmetic
// stages, twelve divider stages (four quotient bits each, for the
// 48-bit radius division) and the output register. Throughput is one
// request per cycle while the result channel does not stall.
// Each stage has its own valid bit and advances when the stage after it is
// empty or advancing, so bubbles close up and a stalled result only holds
// the stages behind it once they are full. Nothing is dropped or repeated.
// Reset clears all valid bits and returns the registers to their reset
// values (roll_radius = 1.0, everything else zero).
// ----------------------------------------------------------------------------
`default_nettype none

module particle_floor_collision (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  pfc_particle_if.sink         particle,
  pfc_result_if.source         result
);

  localparam int NS   = 5 + pfc_pkg::DIV_STAGES;  // total stages
  localparam int S_A  = 0;
  localparam int S_B  = 1;
  localparam int S_C  = 2;
  localparam int S_D  = 3;
  localparam int S_V0 = 4;                         // first divider stage
  localparam int S_F  = NS - 1;                    // output register

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]         mode_flags;
  logic signed [23:0] plane_height;
  logic [18:0]        contact_offset;
  logic [16:0]        bounce;
  logic [20:0]        friction;
  logic [19:0]        rest_speed;
  logic [18:0]        roll_radius;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags     <= '0;
      plane_height   <= '0;
      contact_offset <= '0;
      bounce         <= '0;
      friction       <= '0;
      rest_speed     <= '0;
      roll_radius    <= 19'd65536;
    end else if (cfg_wr) begin
      unique case (pfc_pkg::reg_idx_t'(paddr[4:2]))
        pfc_pkg::REG_MODE:     mode_flags     <= pwdata[2:0];
        pfc_pkg::REG_PLANE:    plane_height   <= pwdata[23:0];
        pfc_pkg::REG_OFFSET:   contact_offset <= pwdata[18:0];
        pfc_pkg::REG_BOUNCE:   bounce         <= pwdata[16:0];
        pfc_pkg::REG_FRICTION: friction       <= pwdata[20:0];
        pfc_pkg::REG_REST:     rest_speed     <= pwdata[19:0];
        pfc_pkg::REG_RADIUS:   roll_radius    <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pfc_pkg::reg_idx_t'(paddr[4:2]))
      pfc_pkg::REG_MODE:     prdata = {29'd0, mode_flags};
      pfc_pkg::REG_PLANE:    prdata = {{8{plane_height[23]}}, plane_height};
      pfc_pkg::REG_OFFSET:   prdata = {13'd0, contact_offset};
      pfc_pkg::REG_BOUNCE:   prdata = {15'd0, bounce};
      pfc_pkg::REG_FRICTION: prdata = {11'd0, friction};
      pfc_pkg::REG_REST:     prdata = {12'd0, rest_speed};
      pfc_pkg::REG_RADIUS:   prdata = {13'd0, roll_radius};
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage flow control: a stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[S_F] = !vld[S_F] || result.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign particle.ready = en[S_A];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[S_A]) vld[S_A] <= particle.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: scale selection and the four products
  // --------------------------------------------------------------------------
  logic [30:0] s_val;
  logic [31:0] impact;

  always_comb begin
    if (!mode_flags[pfc_pkg::FLAG_SCALE]) begin
      s_val = 31'd65536;
    end else if (particle.scale_y[31]) begin
      s_val = '0;
    end else begin
      s_val = particle.scale_y[30:0];
    end
    impact = ~particle.vel_y + 32'd1;   // magnitude of a falling speed
  end

  logic signed [31:0] a_py, a_vx, a_vy, a_vz;
  logic [49:0]        a_fprod, a_rprod;
  logic [37:0]        a_fricprod;
  logic [48:0]        a_bprod;
  logic               a_falling, a_fast, a_en, a_roll;

  always_ff @(posedge clk) begin
    if (en[S_A]) begin
      a_py       <= particle.pos_y;
      a_vx       <= particle.vel_x;
      a_vy       <= particle.vel_y;
      a_vz       <= particle.vel_z;
      a_fprod    <= contact_offset * s_val;
      a_rprod    <= roll_radius * s_val;
      a_fricprod <= friction * particle.delta_time;
      a_bprod    <= impact * bounce;
      a_falling  <= particle.vel_y[31];
      a_fast     <= impact > {12'd0, rest_speed};
      a_en       <= mode_flags[pfc_pkg::FLAG_ENABLE];
      a_roll     <= mode_flags[pfc_pkg::FLAG_ROLL];
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: floor height, decay, radius, bounced speed
  // --------------------------------------------------------------------------
  logic signed [49:0] floor_sum;
  logic [21:0]        fric_term;

  assign floor_sum = {{26{plane_height[23]}}, plane_height} + $signed({16'd0, a_fprod[49:16]});
  assign fric_term = a_fricprod[37:16];

  logic signed [31:0]          b_floor, b_py, b_vx, b_vz, b_vy_hit, b_vy_pass;
  logic [16:0]                 b_decay;
  logic [pfc_pkg::DEN_W-1:0]   b_radius;
  logic                        b_en, b_roll;

  always_ff @(posedge clk) begin
    if (en[S_B]) begin
      b_floor <= pfc_pkg::sat32(floor_sum);
      b_decay <= (fric_term >= 22'(pfc_pkg::ONE_Q16)) ? 17'd0
                                                      : pfc_pkg::ONE_Q16 - fric_term[16:0];
      b_radius <= (a_rprod[49:16] < pfc_pkg::MIN_RADIUS) ? pfc_pkg::MIN_RADIUS
                                                         : a_rprod[49:16];
      if (!a_falling) begin
        b_vy_hit <= a_vy;
      end else if (a_fast) begin
        b_vy_hit <= pfc_pkg::sat32($signed({17'd0, a_bprod[48:16]}));
      end else begin
        b_vy_hit <= '0;
      end
      b_vy_pass <= a_vy;   // vel_y passes untouched without contact
      b_py   <= a_py;
      b_vx   <= a_vx;
      b_vz   <= a_vz;
      b_en   <= a_en;
      b_roll <= a_roll;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: contact test and friction products
  // --------------------------------------------------------------------------
  logic                        hit;
  assign hit = b_en && (b_py <= b_floor);

  logic signed [31:0]          c_py, c_vy, c_vx, c_vz;
  logic signed [49:0]          c_xprod, c_zprod;
  logic                        c_contact, c_spin;
  logic [pfc_pkg::DEN_W-1:0]   c_radius;

  always_ff @(posedge clk) begin
    if (en[S_C]) begin
      c_contact <= hit;
      c_spin    <= hit && b_roll;
      c_py      <= hit ? b_floor : b_py;
      c_vy      <= hit ? b_vy_hit : b_vy_pass;
      c_vx      <= b_vx;
      c_vz      <= b_vz;
      c_xprod   <= b_vx * $signed({1'b0, b_decay});
      c_zprod   <= b_vz * $signed({1'b0, b_decay});
      c_radius  <= b_radius;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: damped velocities and divider set-up
  // --------------------------------------------------------------------------
  logic signed [31:0] vx_new, vz_new;
  logic [31:0]        mag_x, mag_z;

  assign vx_new = c_contact ? c_xprod[47:16] : c_vx;
  assign vz_new = c_contact ? c_zprod[47:16] : c_vz;
  assign mag_x  = vz_new[31] ? ~vz_new + 32'd1 : vz_new;   // spin_x from vel_z
  assign mag_z  = vx_new[31] ? ~vx_new + 32'd1 : vx_new;   // spin_z from -vel_x

  pfc_pkg::carry_t     d_carry;
  pfc_pkg::div_state_t d_dx, d_dz;
  logic [pfc_pkg::DEN_W-1:0] d_radius;

  always_ff @(posedge clk) begin
    if (en[S_D]) begin
      d_carry.py      <= c_py;
      d_carry.vx      <= vx_new;
      d_carry.vy      <= c_vy;
      d_carry.vz      <= vz_new;
      d_carry.contact <= c_contact;
      d_carry.spin    <= c_spin;
      d_carry.neg_x   <= vz_new[31];
      d_carry.neg_z   <= !vx_new[31] && (vx_new != 32'sd0);
      d_dx.rem        <= '0;
      d_dx.dq         <= {mag_x, 16'd0};
      d_dz.rem        <= '0;
      d_dz.dq         <= {mag_z, 16'd0};
      d_radius        <= c_radius;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: both spin quotients share the radius
  // --------------------------------------------------------------------------
  pfc_pkg::carry_t           v_carry  [pfc_pkg::DIV_STAGES];
  pfc_pkg::div_state_t       v_dx     [pfc_pkg::DIV_STAGES];
  pfc_pkg::div_state_t       v_dz     [pfc_pkg::DIV_STAGES];
  logic [pfc_pkg::DEN_W-1:0] v_radius [pfc_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en[S_V0]) begin
      v_carry[0]  <= d_carry;
      v_dx[0]     <= pfc_pkg::div_step(d_dx, d_radius);
      v_dz[0]     <= pfc_pkg::div_step(d_dz, d_radius);
      v_radius[0] <= d_radius;
    end
    for (int k = 1; k < pfc_pkg::DIV_STAGES; k++) begin
      if (en[S_V0 + k]) begin
        v_carry[k]  <= v_carry[k-1];
        v_dx[k]     <= pfc_pkg::div_step(v_dx[k-1], v_radius[k-1]);
        v_dz[k]     <= pfc_pkg::div_step(v_dz[k-1], v_radius[k-1]);
        v_radius[k] <= v_radius[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: sign, saturate, gate spin
  // --------------------------------------------------------------------------
  localparam int LAST = pfc_pkg::DIV_STAGES - 1;

  pfc_pkg::carry_t    f_in;
  logic [47:0]        qx, qz;
  logic signed [31:0] spin_x_val, spin_z_val;

  assign f_in = v_carry[LAST];
  assign qx   = v_dx[LAST].dq;
  assign qz   = v_dz[LAST].dq;

  always_comb begin
    if (!f_in.neg_x) begin
      spin_x_val = (qx > 48'h7fffffff) ? 32'sh7fffffff : qx[31:0];
    end else begin
      spin_x_val = (qx > 48'h80000000) ? 32'sh80000000 : ~qx[31:0] + 32'd1;
    end
    if (!f_in.neg_z) begin
      spin_z_val = (qz > 48'h7fffffff) ? 32'sh7fffffff : qz[31:0];
    end else begin
      spin_z_val = (qz > 48'h80000000) ? 32'sh80000000 : ~qz[31:0] + 32'd1;
    end
  end

  logic signed [31:0] f_py, f_vx, f_vy, f_vz, f_spx, f_spz;
  logic               f_spin, f_contact;

  always_ff @(posedge clk) begin
    if (en[S_F]) begin
      f_py      <= f_in.py;
      f_vx      <= f_in.vx;
      f_vy      <= f_in.vy;
      f_vz      <= f_in.vz;
      f_spx     <= f_in.spin ? spin_x_val : 32'sd0;
      f_spz     <= f_in.spin ? spin_z_val : 32'sd0;
      f_spin    <= f_in.spin;
      f_contact <= f_in.contact;
    end
  end

  assign result.valid      = vld[S_F];
  assign result.new_pos_y  = f_py;
  assign result.new_vel_x  = f_vx;
  assign result.new_vel_y  = f_vy;
  assign result.new_vel_z  = f_vz;
  assign result.spin_x     = f_spx;
  assign result.spin_z     = f_spz;
  assign result.spin_write = f_spin;
  assign result.contact    = f_contact;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_spin_needs_contact: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!result.spin_write || result.contact))
    else $error("spin written without floor contact");

  a_spin_zero_when_idle: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.spin_write) |-> (result.spin_x == 32'sd0 && result.spin_z == 32'sd0))
    else $error("spin fields non-zero without spin write");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[S_D] && !en[S_D]) |=> (vld[S_D] && $stable(d_carry)))
    else $error("stalled stage lost or changed its contents");

endmodule

`default_nettype wire

[verif/particle_floor_collision_test.sv]
// ----------------------------------------------------------------------------
// particle_floor_collision_test: self-checking bench for the floor collision
// Drives particle requests under several register settings and idling
// patterns, predicts each result in the bench and compares every field.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_floor_collision_test;

  typedef struct packed {
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] scale_y;
    logic [16:0]        delta_time;
  } particle_t;

  typedef struct packed {
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] spin_x;
    logic signed [31:0] spin_z;
    logic               spin_write;
    logic               contact;
  } response_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pfc_particle_if particle ();
  pfc_result_if   result ();

  particle_floor_collision u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .particle(particle.sink), .result(result.source)
  );

  // Bench copy of the registers, kept at the block's widths
  logic [2:0]         cfg_mode;
  logic signed [23:0] cfg_plane;
  logic [18:0]        cfg_offset;
  logic [16:0]        cfg_bounce;
  logic [20:0]        cfg_friction;
  logic [19:0]        cfg_rest;
  logic [18:0]        cfg_radius;

  particle_t pending_requests[$];
  response_t expected_responses[$];
  int        errors;
  int        send_idle_pct;
  int        recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit: the bench's 1632 items with heavy stalls fit well inside this
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic signed [63:0] floor_q16(input logic signed [63:0] p);
    return p >>> 16;   // arithmetic shift floors toward minus infinity
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Predict the floor response of one particle from the bench registers
  function automatic response_t floor_response(input particle_t p);
    response_t          r;
    logic signed [63:0] py, vx, vy, vz, s, floor_y, decay, rad;
    py = p.pos_y; vx = p.vel_x; vy = p.vel_y; vz = p.vel_z;
    r = '0;
    if (cfg_mode[pfc_pkg::FLAG_ENABLE]) begin
      if (cfg_mode[pfc_pkg::FLAG_SCALE]) s = (p.scale_y < 0) ? 64'sd0 : 64'(p.scale_y);
      else s = 64'sd65536;
      floor_y = clamp32(64'(cfg_plane) + floor_q16($signed({45'd0, cfg_offset}) * s));
      if (py <= floor_y) begin
        r.contact = 1'b1;
        py = floor_y;
        if (vy < 0) begin
          if (-vy > $signed({44'd0, cfg_rest}))
            vy = clamp32(floor_q16(-vy * $signed({47'd0, cfg_bounce})));
          else vy = 0;
        end
        decay = 64'sd65536 - floor_q16($signed({43'd0, cfg_friction})
                                       * $signed({47'd0, p.delta_time}));
        if (decay < 0) decay = 0;
        vx = floor_q16(vx * decay);
        vz = floor_q16(vz * decay);
        if (cfg_mode[pfc_pkg::FLAG_ROLL]) begin
          rad = floor_q16($signed({45'd0, cfg_radius}) * s);
          if (rad < 66) rad = 66;
          r.spin_x = 32'(clamp32((vz * 65536) / rad));
          r.spin_z = 32'(clamp32((-vx * 65536) / rad));
          r.spin_write = 1'b1;
        end
      end
    end
    r.new_pos_y = py[31:0]; r.new_vel_x = vx[31:0]; r.new_vel_y = vy[31:0];
    r.new_vel_z = vz[31:0];
    return r;
  endfunction

  // Driver: hold valid and payload until accepted, idle at random between requests
  always @(posedge clk) begin
    if (rst) begin
      particle.valid <= 1'b0;
    end else if (!particle.valid || particle.ready) begin
      if (particle.valid) expected_responses.push_back(floor_response(
          {particle.pos_y, particle.vel_x, particle.vel_y, particle.vel_z,
           particle.scale_y, particle.delta_time}));
      if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        particle_t p;
        p = pending_requests.pop_front();
        particle.valid      <= 1'b1;
        particle.pos_y      <= p.pos_y;
        particle.vel_x      <= p.vel_x;
        particle.vel_y      <= p.vel_y;
        particle.vel_z      <= p.vel_z;
        particle.scale_y    <= p.scale_y;
        particle.delta_time <= p.delta_time;
      end else begin
        particle.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        response_t got, want;
        got = {result.new_pos_y, result.new_vel_x, result.new_vel_y, result.new_vel_z,
               result.spin_x, result.spin_z, result.spin_write, result.contact};
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_responses.pop_front();
          if (got.new_pos_y !== want.new_pos_y)
            $display("%0t: new_pos_y exp %h got %h", $time, want.new_pos_y, got.new_pos_y);
          if (got.new_vel_x !== want.new_vel_x)
            $display("%0t: new_vel_x exp %h got %h", $time, want.new_vel_x, got.new_vel_x);
          if (got.new_vel_y !== want.new_vel_y)
            $display("%0t: new_vel_y exp %h got %h", $time, want.new_vel_y, got.new_vel_y);
          if (got.new_vel_z !== want.new_vel_z)
            $display("%0t: new_vel_z exp %h got %h", $time, want.new_vel_z, got.new_vel_z);
          if (got.spin_x !== want.spin_x)
            $display("%0t: spin_x exp %h got %h", $time, want.spin_x, got.spin_x);
          if (got.spin_z !== want.spin_z)
            $display("%0t: spin_z exp %h got %h", $time, want.spin_z, got.spin_z);
          if (got.spin_write !== want.spin_write)
            $display("%0t: spin_write exp %b got %b", $time, want.spin_write, got.spin_write);
          if (got.contact !== want.contact)
            $display("%0t: contact exp %b got %b", $time, want.contact, got.contact);
          if (got !== want) errors++;
        end
      end
      result.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Write one register over APB: setup cycle, then access cycle
  task automatic write_reg(input pfc_pkg::reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      pfc_pkg::REG_MODE:     cfg_mode     = value[2:0];
      pfc_pkg::REG_PLANE:    cfg_plane    = value[23:0];
      pfc_pkg::REG_OFFSET:   cfg_offset   = value[18:0];
      pfc_pkg::REG_BOUNCE:   cfg_bounce   = value[16:0];
      pfc_pkg::REG_FRICTION: cfg_friction = value[20:0];
      pfc_pkg::REG_REST:     cfg_rest     = value[19:0];
      pfc_pkg::REG_RADIUS:   cfg_radius   = value[18:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [2:0] mode, input logic [31:0] plane,
                           input logic [31:0] offs, input logic [31:0] bnc,
                           input logic [31:0] fric, input logic [31:0] rest,
                           input logic [31:0] rad);
    write_reg(pfc_pkg::REG_MODE, mode);
    write_reg(pfc_pkg::REG_PLANE, plane);
    write_reg(pfc_pkg::REG_OFFSET, offs);
    write_reg(pfc_pkg::REG_BOUNCE, bnc);
    write_reg(pfc_pkg::REG_FRICTION, fric);
    write_reg(pfc_pkg::REG_REST, rest);
    write_reg(pfc_pkg::REG_RADIUS, rad);
  endtask

  // Wait until every request has gone in and every result has come out;
  // sample at the falling edge so the driver's updates have settled
  task automatic drain();
    while (pending_requests.size() > 0 || particle.valid || expected_responses.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return 32'($signed($urandom_range(1310720)) - 655360);
    endcase
  endfunction

  // Random particle; mostly near the floor so contact is common
  function automatic particle_t rand_particle();
    particle_t p;
    p.pos_y   = ($urandom_range(3) == 0) ? rand_word()
              : 32'($signed(cfg_plane) + $signed($urandom_range(1048576)) - 524288);
    p.vel_x   = rand_word();
    p.vel_y   = rand_word();
    p.vel_z   = rand_word();
    p.scale_y = ($urandom_range(3) == 0) ? rand_word() : 32'($urandom_range(196608));
    p.delta_time = ($urandom_range(7) == 0) ? 17'($urandom()) : 17'($urandom_range(65536));
    return p;
  endfunction

  task automatic random_batch(input int n);
    repeat (n) pending_requests.push_back(rand_particle());
    drain();
  endtask

  task automatic random_config();
    write_all(3'($urandom()), 32'($signed($urandom_range(13107200)) - 6553600),
              ($urandom_range(3) == 0) ? $urandom() : $urandom_range(327680),
              ($urandom_range(3) == 0) ? $urandom() : $urandom_range(65536),
              ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1310720),
              ($urandom_range(3) == 0) ? $urandom() : $urandom_range(655360),
              ($urandom_range(3) == 0) ? $urandom() : $urandom_range(327680));
  endtask

  initial begin
    particle_t d;
    errors = 0;
    send_idle_pct = 15; recv_idle_pct = 50;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    cfg_mode = 0; cfg_plane = 0; cfg_offset = 0; cfg_bounce = 0;
    cfg_friction = 0; cfg_rest = 0; cfg_radius = 19'd65536;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: disabled pass-through at reset values
    d = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 17'h1ffff};
    pending_requests.push_back(d);
    drain();

    // Enabled with rolling and scale: extremes, above floor, rising, landing, bounce
    write_all(3'b111, 32'hff9c_0000, 327680, 65536, 1310720, 655360, 327680);
    pending_requests.push_back('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                                 32'sh8000_0000, 32'sh7fff_ffff, 17'd65536});
    pending_requests.push_back('{32'sh7fff_ffff, 1, -1, 1, 65536, 0});
    pending_requests.push_back('{-32'sd7000000, 65536, 65536, -65536, 65536, 100});
    pending_requests.push_back('{-32'sd7000000, 65536, -655360, 65536, 65536, 0});
    pending_requests.push_back('{-32'sd7000000, -65536, -655361, 65536, -5, 1});
    pending_requests.push_back('{-32'sd7000000, 32'sh8000_0000, 0, 32'sh7fff_ffff, 0, 65536});
    pending_requests.push_back('{-32'sd6553600, 12345, -999999, -12345, 1, 30000});
    drain();
    // Tiny radius, no friction, full bounce, plane at top
    write_all(3'b011, 6553600, 0, 65536, 0, 0, 0);
    pending_requests.push_back('{0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 0, 65536});
    pending_requests.push_back('{6553600, -1, -1, 1, 0, 0});
    pending_requests.push_back('{6553601, 5, -5, 5, 0, 0});
    drain();
    // Out-of-range register bits
    write_all(3'b101, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff);
    pending_requests.push_back('{32'sh8000_0000, 1000, -70000000, 1000, 32'sh7fff_ffff, 65536});
    drain();

    // Random phases through the three idling patterns
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle_pct = 50; recv_idle_pct = 15; end
      if (ph == 8) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      random_config();
      random_batch(135);
    end

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
